// ===== rtl/cvp_pkg.sv =====
// Shared types, codes and character helpers for the command verb parser.
// No dependencies; imported by cvp_core and command_verb_parser.
package cvp_pkg;

  // Size limits of a request and of one token
  localparam int unsigned MAX_REQUEST = 64;
  localparam int unsigned MAX_TOKEN   = 8;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_BEGIN = 2'd2,
    KIND_DONE  = 2'd3
  } kind_t;

  // Verdict codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_ARGS     = 3'd3,
    ST_BUSY     = 3'd4,
    ST_OVERSIZE = 3'd5
  } status_t;

  // Verb codes
  localparam logic [2:0] V_NONE         = 3'd0;
  localparam logic [2:0] V_STATUS       = 3'd1;
  localparam logic [2:0] V_UPDATE       = 3'd2;
  localparam logic [2:0] V_UPDATE_FORCE = 3'd3;
  localparam logic [2:0] V_SWITCH       = 3'd4;
  localparam logic [2:0] V_GOLDEN       = 3'd5;

  // Result types
  localparam logic RT_VERDICT = 1'b0;
  localparam logic RT_TAKE    = 1'b1;

  // Match flag positions
  localparam int unsigned W_STATUS = 0;
  localparam int unsigned W_UPDATE = 1;
  localparam int unsigned W_SWITCH = 2;
  localparam int unsigned W_GOLDEN = 3;
  localparam int unsigned W_FORCE  = 4;
  localparam int unsigned N_WORDS  = 5;

  // One registered input item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // Result of one step, before the output register
  typedef struct packed {
    logic       valid;
    logic       result_type;
    status_t    status;
    logic [2:0] verb;
  } res_t;

  // Space, tab, CR and LF
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  // Fold a..z to upper case, leave everything else
  function automatic logic [7:0] fold(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Length of each keyword
  function automatic logic [3:0] word_len(input int unsigned w);
    return (w == W_FORCE) ? 4'd5 : 4'd6;
  endfunction

  // Character of a keyword at a position, zero past its end
  function automatic logic [7:0] word_char(input int unsigned w, input logic [3:0] p);
    logic [47:0] txt;
    txt = 48'h0;
    case (w)
      W_STATUS: txt = "SUTATS";
      W_UPDATE: txt = "ETADPU";
      W_SWITCH: txt = "HCTIWS";
      W_GOLDEN: txt = "NEDLOG";
      default:  txt = {8'h00, "ECROF"};
    endcase
    if (p >= 4'd6) begin
      return 8'h00;
    end
    return txt[8*p[2:0] +: 8];
  endfunction

  // Apply one token character: returns {token_count, match_flags}
  function automatic logic [8:0] match_char(input logic [4:0] fl, input logic [3:0] tc,
                                            input logic [7:0] c);
    logic [7:0] uc;
    logic [4:0] fo;
    logic [3:0] to;
    uc = fold(c);
    fo = fl;
    for (int unsigned i = 0; i < N_WORDS; i++) begin
      if (tc >= word_len(i) || uc != word_char(i, tc)) begin
        fo[i] = 1'b0;
      end
    end
    to = (tc < 4'd15) ? tc + 4'd1 : tc;
    return {to, fo};
  endfunction

  // A verb token is complete and matched
  function automatic logic verb_ok(input logic [4:0] fl, input logic [3:0] tc);
    return (tc <= 4'(MAX_TOKEN)) && (tc == 4'd6) && (|fl[W_GOLDEN:W_STATUS]);
  endfunction

  // The FORCE operand is complete and matched
  function automatic logic force_ok(input logic [4:0] fl, input logic [3:0] tc);
    return (tc <= 4'(MAX_TOKEN)) && (tc == 4'd5) && fl[W_FORCE];
  endfunction

  // Verb code of the lowest matching keyword
  function automatic logic [2:0] verb_code(input logic [4:0] fl);
    if (fl[W_STATUS]) return V_STATUS;
    if (fl[W_UPDATE]) return V_UPDATE;
    if (fl[W_SWITCH]) return V_SWITCH;
    if (fl[W_GOLDEN]) return V_GOLDEN;
    return V_NONE;
  endfunction

endpackage

// ===== rtl/command_verb_parser.sv =====
// Top level of the command verb parser: input register, parser core, result register.
// Depends on cvp_pkg and cvp_core.
//
//  channel | ports              | item contents
//  --------+--------------------+------------------------------------------------
//  in      | in_tvalid/in_tready| tuser = kind, tdata = data_byte, tlast = last_byte
//  out     | out_tvalid/tready  | tuser = result_type, tdata = status, verb
//
// One item is taken per cycle unless the input stalls; a result is presented on out_tvalid
// from the result register once its item has passed the input register and one pass
// through the parser core, and it is held there until out_tready takes it.
// Reset is synchronous and clears the parser, the pending verb and busy state.
// While out_tready is low the result is held; items without a result keep flowing,
// and the input stalls only when an item with a result finds the result register full.
module command_verb_parser
  import cvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [1:0] in_tuser,   // [1:0] kind
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] status, [5:3] verb, [7:6] zero
  output logic       out_tuser   // result_type
);

  item_t      item_r;
  logic       in_valid_r;
  logic       out_valid_r;
  res_t       out_r;
  res_t       res;
  logic       out_free;
  logic       need_out;
  logic       adv;

  // Advance the registered item when its result, if any, has room
  assign need_out  = (item_r.kind == KIND_TAKE) ||
                     ((item_r.kind == KIND_BYTE) && item_r.last_byte);
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = in_valid_r && (!need_out || out_free);
  assign in_tready = !in_valid_r || adv;

  cvp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind      <= kind_t'(in_tuser);
      item_r.data_byte <= in_tdata;
      item_r.last_byte <= in_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_r.verb, out_r.status};
  assign out_tuser  = out_r.result_type;

endmodule

// ===== rtl/cvp_core.sv =====
// Parser state and single-step update logic for the command verb parser.
// Depends on cvp_pkg for item and result types, codes and matcher helpers.
module cvp_core
  import cvp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  output res_t  res
);

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_VERB    = 3'd1,
    PH_AFTER   = 3'd2,
    PH_OPND    = 3'd3,
    PH_TRAIL   = 3'd4,
    PH_ARGS    = 3'd5,
    PH_UNKNOWN = 3'd6,
    PH_DROPPED = 3'd7
  } phase_t;

  phase_t     phase_r,   phase_nxt;
  logic [3:0] tok_cnt_r, tok_cnt_nxt;
  logic [4:0] flags_r,   flags_nxt;
  logic [2:0] pverb_r,   pverb_nxt;
  logic [7:0] byte_cnt_r, byte_cnt_nxt;
  logic       ended_r,   ended_nxt;
  logic [2:0] pend_r,    pend_nxt;
  logic       busy_r,    busy_nxt;

  logic [7:0] c;
  logic       ws;
  status_t    vst;
  logic [2:0] vverb;

  assign c  = item.data_byte;
  assign ws = is_ws(item.data_byte);

  // Work out the state after this item and its result
  always_comb begin
    phase_nxt    = phase_r;
    tok_cnt_nxt  = tok_cnt_r;
    flags_nxt    = flags_r;
    pverb_nxt    = pverb_r;
    byte_cnt_nxt = byte_cnt_r;
    ended_nxt    = ended_r;
    pend_nxt     = pend_r;
    busy_nxt     = busy_r;
    vst          = ST_OK;
    vverb        = V_NONE;
    res          = '0;
    res.status   = ST_OK;
    if (step_en) begin
      case (item.kind)
        KIND_TAKE: begin
          res.valid       = 1'b1;
          res.result_type = RT_TAKE;
          res.verb        = pend_r;
          if (pend_r != V_NONE) begin
            pend_nxt = V_NONE;
            busy_nxt = 1'b1;
          end
        end
        KIND_BEGIN: begin
          busy_nxt = 1'b1;
        end
        KIND_DONE: begin
          busy_nxt = 1'b0;
        end
        default: begin
          // Count the byte (dropping the request past MAX_REQUEST bytes), then parse it unless the text has ended
          if (phase_nxt != PH_DROPPED) begin
            if (byte_cnt_nxt >= 8'(MAX_REQUEST)) begin
              phase_nxt = PH_DROPPED;
            end else begin
              byte_cnt_nxt = byte_cnt_nxt + 8'd1;
              if (!ended_nxt) begin
                if (c == 8'h00) begin
                  ended_nxt = 1'b1;
                end else begin
                  case (phase_nxt)
                    PH_LEAD: begin
                      if (!ws) begin
                        {tok_cnt_nxt, flags_nxt} = match_char(5'h1F, 4'd0, c);
                        phase_nxt = PH_VERB;
                      end
                    end
                    PH_VERB: begin
                      if (!ws) begin
                        {tok_cnt_nxt, flags_nxt} = match_char(flags_nxt, tok_cnt_nxt, c);
                      end else if (verb_ok(flags_nxt, tok_cnt_nxt)) begin
                        pverb_nxt = verb_code(flags_nxt);
                        phase_nxt = PH_AFTER;
                      end else begin
                        phase_nxt = PH_UNKNOWN;
                      end
                    end
                    PH_AFTER: begin
                      if (!ws) begin
                        if (pverb_nxt != V_UPDATE) begin
                          phase_nxt = PH_ARGS;
                        end else begin
                          {tok_cnt_nxt, flags_nxt} = match_char(5'h1F, 4'd0, c);
                          phase_nxt = PH_OPND;
                        end
                      end
                    end
                    PH_OPND: begin
                      if (!ws) begin
                        {tok_cnt_nxt, flags_nxt} = match_char(flags_nxt, tok_cnt_nxt, c);
                      end else if (force_ok(flags_nxt, tok_cnt_nxt)) begin
                        pverb_nxt = V_UPDATE_FORCE;
                        phase_nxt = PH_TRAIL;
                      end else begin
                        phase_nxt = PH_ARGS;
                      end
                    end
                    PH_TRAIL: begin
                      if (!ws) begin
                        phase_nxt = PH_ARGS;
                      end
                    end
                    default: begin
                    end
                  endcase
                end
              end
            end
          end
          // Final byte: give the verdict and clear the parser
          if (item.last_byte) begin
            case (phase_nxt)
              PH_LEAD: vst = ST_EMPTY;
              PH_VERB: begin
                if (verb_ok(flags_nxt, tok_cnt_nxt)) begin
                  vverb = verb_code(flags_nxt);
                end else begin
                  vst = ST_UNKNOWN;
                end
              end
              PH_AFTER, PH_TRAIL: vverb = pverb_nxt;
              PH_OPND: begin
                if (force_ok(flags_nxt, tok_cnt_nxt)) begin
                  vverb = V_UPDATE_FORCE;
                end else begin
                  vst   = ST_ARGS;
                  vverb = pverb_nxt;
                end
              end
              PH_ARGS: begin
                vst   = ST_ARGS;
                vverb = pverb_nxt;
              end
              PH_UNKNOWN: vst = ST_UNKNOWN;
              default:    vst = ST_OVERSIZE;
            endcase
            if (vst == ST_OK) begin
              if (busy_r || pend_r != V_NONE) begin
                vst = ST_BUSY;
              end else begin
                pend_nxt = vverb;
              end
            end
            res.valid       = 1'b1;
            res.result_type = RT_VERDICT;
            res.status      = vst;
            res.verb        = vverb;
            phase_nxt    = PH_LEAD;
            tok_cnt_nxt  = 4'd0;
            flags_nxt    = 5'h1F;
            pverb_nxt    = V_NONE;
            byte_cnt_nxt = 8'd0;
            ended_nxt    = 1'b0;
          end
        end
      endcase
    end
  end

  // Hold parser, pending verb and busy state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_LEAD;
      tok_cnt_r  <= 4'd0;
      flags_r    <= 5'h1F;
      pverb_r    <= V_NONE;
      byte_cnt_r <= 8'd0;
      ended_r    <= 1'b0;
      pend_r     <= V_NONE;
      busy_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      tok_cnt_r  <= tok_cnt_nxt;
      flags_r    <= flags_nxt;
      pverb_r    <= pverb_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      ended_r    <= ended_nxt;
      pend_r     <= pend_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule
